@@ sv/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
// No dependencies; compiled first.
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  localparam int OPC_W  = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] ATTR_RESET   = 8'h07;

  typedef enum logic [OPC_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_EVAL,
    ST_SC_PRIME,
    ST_SCROLL,
    ST_RD_DATA,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [CHAR_W-1:0] attr;
    logic [CHAR_W-1:0] chr;
  } cell_t;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic [CHAR_W-1:0] cell_attr;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
  } rsp_t;

  typedef struct packed {
    logic valid;
    rsp_t data;
  } emit_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    cell_t             wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

@@ sv/tcw_if.sv @@
// Valid/ready channel interfaces for the text console writer.
// Depends on tcw_pkg.
interface tcw_cmd_if;
  logic                      valid;
  logic                      ready;
  logic [tcw_pkg::OPC_W-1:0]  opcode;
  logic [tcw_pkg::CHAR_W-1:0] char_code;
  logic [tcw_pkg::IDX_W-1:0]  cell_index;

  modport source (output valid, opcode, char_code, cell_index, input ready);
  modport sink   (input valid, opcode, char_code, cell_index, output ready);
endinterface

interface tcw_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [tcw_pkg::CHAR_W-1:0] cell_char;
  logic [tcw_pkg::CHAR_W-1:0] cell_attr;
  logic [tcw_pkg::COL_W-1:0]  cursor_col;
  logic [tcw_pkg::ROW_W-1:0]  cursor_row;

  modport source (output valid, cell_char, cell_attr, cursor_col, cursor_row, input ready);
  modport sink   (input valid, cell_char, cell_attr, cursor_col, cursor_row, output ready);
endinterface

@@ sv/text_console_writer_unit.sv @@
// Top level of the text console writer: APB register, output register,
// sequencer and cell RAM. Depends on tcw_pkg, tcw_if, tcw_seq, tcw_cell_ram.
//
// Usage:
//  - cmd channel (valid/ready) carries one word: opcode, char_code,
//    cell_index. rsp channel returns exactly one word per command: read
//    cell (char/attr, zero unless a read in range) and the cursor after it.
//  - A scroll copies one cell per cycle through the single RAM read port,
//    and a clear zeroes one cell per cycle; a read returns the cell through
//    the registered RAM read port. One command is worked on at a time.
//  - After reset the cursor is at the home position, text_attribute is 7
//    and a clearing pass zeroes the cell RAM; cmd.ready stays low until
//    it ends. APB writes are taken at all times.
//  - The rsp word sits in an output register; a new command is accepted
//    while it waits, but the next result is held back until rsp.ready
//    drains the register.
//  - APB: register text_attribute at byte address 0, pready always high.
module text_console_writer_unit (
  input  logic                        clk,
  input  logic                        rst,
  tcw_cmd_if.sink                     cmd,
  tcw_rsp_if.source                   rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcw_pkg::APB_AW-1:0]  paddr,
  input  logic [tcw_pkg::APB_DW-1:0]  pwdata,
  output logic [tcw_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import tcw_pkg::*;

  logic [CHAR_W-1:0] text_attribute;
  logic              out_valid;
  rsp_t              out_data;
  logic              out_free;
  emit_t             emit;
  mem_req_t          mem;
  cell_t             rdata;
  logic              reg_hit;

  // --- configuration register ---
  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_AW-1] == 1'b0);   // word 0 only
  assign prdata  = reg_hit ? APB_DW'(text_attribute) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= ATTR_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      text_attribute <= pwdata[CHAR_W-1:0];
    end
  end

  // --- output register: frees the sequencer from rsp stalls ---
  assign out_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.valid) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_data <= emit.data;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.cell_char  = out_data.cell_char;
  assign rsp.cell_attr  = out_data.cell_attr;
  assign rsp.cursor_col = out_data.cursor_col;
  assign rsp.cursor_row = out_data.cursor_row;

  // --- sequencer ---
  tcw_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .opcode         (cmd.opcode),
    .char_code      (cmd.char_code),
    .cell_index     (cmd.cell_index),
    .text_attribute (text_attribute),
    .out_free       (out_free),
    .emit           (emit),
    .mem            (mem),
    .rdata          (rdata)
  );

  // --- cell store: {attr, char} per cell ---
  tcw_cell_ram #(
    .DEPTH (CELL_COUNT),
    .WIDTH ($bits(cell_t))
  ) u_ram (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .re    (mem.re),
    .raddr (mem.raddr),
    .rdata (rdata)
  );

`ifndef ASSERT_OFF
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    emit.valid |-> out_free)
    else $error("result emitted into a full output register");
`endif

endmodule

@@ sv/tcw_cell_ram.sv @@
// Generic simple dual-port RAM, one write and one read port, registered read.
// No dependencies.
module tcw_cell_ram #(
  parameter int DEPTH = 2000,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // rdata holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/tcw_seq.sv @@
// Sequencer: cursor, put/read/clear control, scroll and clear sweeps.
// Depends on tcw_pkg; drives the cell RAM through a mem_req_t.
module tcw_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  output logic                      cmd_ready,
  input  logic [tcw_pkg::OPC_W-1:0]  opcode,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code,
  input  logic [tcw_pkg::IDX_W-1:0]  cell_index,
  input  logic [tcw_pkg::CHAR_W-1:0] text_attribute,
  input  logic                      out_free,
  output tcw_pkg::emit_t            emit,
  output tcw_pkg::mem_req_t         mem,
  input  tcw_pkg::cell_t            rdata
);
  import tcw_pkg::*;

  state_t             state, state_next;
  logic [ADDR_W-1:0]  cnt, cnt_next;
  logic [COL_W-1:0]   col, col_next;
  logic [ROW_W-1:0]   row, row_next;
  logic               wrapped, wrapped_next;
  logic               clr_op, clr_op_next;
  logic               idx_ok, idx_ok_next;
  logic [CHAR_W-1:0]  chr, chr_next;

  logic               nl, need_wrap, last_cell;
  logic [ADDR_W-1:0]  put_addr;
  logic [ADDR_W:0]    sc_raddr;

  assign nl        = (chr == NEWLINE_CODE);
  assign need_wrap = !wrapped && (nl || (col > COL_W'(COLUMNS - 1)));
  assign last_cell = (cnt == ADDR_W'(CELL_COUNT - 1));
  assign put_addr  = ADDR_W'(ADDR_W'(row) * ADDR_W'(COLUMNS)) + ADDR_W'(col);
  // source row for the next scroll write, one line below
  assign sc_raddr  = (ADDR_W + 1)'(cnt) + (ADDR_W + 1)'(COLUMNS + 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLR;
      cnt     <= '0;
      col     <= '0;
      row     <= '0;
      wrapped <= 1'b0;
      clr_op  <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      col     <= col_next;
      row     <= row_next;
      wrapped <= wrapped_next;
      clr_op  <= clr_op_next;
    end
  end

  always_ff @(posedge clk) begin
    chr    <= chr_next;
    idx_ok <= idx_ok_next;
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    col_next     = col;
    row_next     = row;
    wrapped_next = wrapped;
    clr_op_next  = clr_op;
    chr_next     = chr;
    idx_ok_next  = idx_ok;
    cmd_ready    = 1'b0;
    emit         = '0;
    mem          = '0;

    case (state)
      ST_CLR: begin
        mem.we    = 1'b1;
        mem.waddr = cnt;
        cnt_next  = cnt + 1'b1;
        if (last_cell) begin
          cnt_next   = '0;
          state_next = clr_op ? ST_FIN : ST_IDLE;
        end
      end

      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          chr_next     = char_code;
          wrapped_next = 1'b0;
          case (opcode_t'(opcode))
            OP_PUT: state_next = ST_EVAL;
            OP_CLEAR: begin
              cnt_next    = '0;
              col_next    = '0;
              row_next    = '0;
              clr_op_next = 1'b1;
              state_next  = ST_CLR;
            end
            OP_READ: begin
              idx_ok_next = ({1'b0, cell_index} < (IDX_W + 1)'(CELL_COUNT));
              mem.re      = idx_ok_next;
              mem.raddr   = ADDR_W'(cell_index);
              state_next  = ST_RD_DATA;
            end
            default: state_next = ST_FIN;
          endcase
        end
      end

      ST_EVAL: begin
        if (need_wrap) begin
          if (row >= ROW_W'(ROWS)) begin
            row_next   = ROW_W'(ROWS - 1);
            state_next = ST_SC_PRIME;
          end else begin
            col_next     = '0;
            row_next     = row + 1'b1;
            wrapped_next = 1'b1;
          end
        end else if (nl) begin
          if (out_free) begin
            emit.valid = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (row > ROW_W'(ROWS - 1)) begin
          // deferred scroll before a printable character
          row_next   = ROW_W'(ROWS - 1);
          state_next = ST_SC_PRIME;
        end else if (out_free) begin
          mem.we         = 1'b1;
          mem.waddr      = put_addr;
          mem.wdata.chr  = chr;
          mem.wdata.attr = text_attribute;
          col_next       = col + 1'b1;
          emit.valid     = 1'b1;
          state_next     = ST_IDLE;
        end
      end

      ST_SC_PRIME: begin
        mem.re     = 1'b1;
        mem.raddr  = ADDR_W'(COLUMNS);
        cnt_next   = '0;
        state_next = ST_SCROLL;
      end

      ST_SCROLL: begin
        // write cnt from the row below (blank on the last row), read one ahead; addresses never meet
        mem.we    = 1'b1;
        mem.waddr = cnt;
        if (cnt < ADDR_W'(CELL_COUNT - COLUMNS)) begin
          mem.wdata = rdata;
        end
        mem.re    = (sc_raddr < (ADDR_W + 1)'(CELL_COUNT));
        mem.raddr = sc_raddr[ADDR_W-1:0];
        cnt_next  = cnt + 1'b1;
        if (last_cell) begin
          cnt_next   = '0;
          state_next = ST_EVAL;
        end
      end

      ST_RD_DATA: begin
        if (out_free) begin
          emit.valid = 1'b1;
          if (idx_ok) begin
            emit.data.cell_char = rdata.chr;
            emit.data.cell_attr = rdata.attr;
          end
          state_next = ST_IDLE;
        end
      end

      ST_FIN: begin
        if (out_free) begin
          emit.valid  = 1'b1;
          clr_op_next = 1'b0;
          state_next  = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase

    emit.data.cursor_col = col_next;
    emit.data.cursor_row = row_next;
  end

`ifndef ASSERT_OFF
  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    row <= ROW_W'(ROWS))
    else $error("cursor row beyond pending row");

  a_idle_col: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (col <= COL_W'(COLUMNS)))
    else $error("cursor column out of range at idle");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (mem.we && mem.re) |-> (mem.waddr != mem.raddr))
    else $error("read and write to the same cell in one cycle");

  a_emit_ends: assert property (@(posedge clk) disable iff (rst)
    emit.valid |=> (state == ST_IDLE))
    else $error("word emitted without returning to idle");
`endif

endmodule

@@ tb/tcw_tb_pkg.sv @@
// Register map of the text console writer as the testbench sees it.
// No dependencies; compiled before the checker and the testbench top.
package tcw_tb_pkg;

  localparam int REG_STRIDE = 4;

  typedef enum int {
    REG_TEXT_ATTR   = 0,
    REG_BEYOND_LAST = 1
  } reg_index_t;

endpackage

@@ tb/tcw_tb_checker.sv @@
// Console shadow and word checker for the text console writer.
// Depends on tcw_pkg, tcw_tb_pkg and the channel interfaces in tcw_if.
module tcw_tb_checker (
  input  logic                       clk,
  input  logic                       rst,
  tcw_cmd_if                         cmd,
  tcw_rsp_if                         rsp,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [tcw_pkg::APB_AW-1:0] paddr,
  input  logic [tcw_pkg::APB_DW-1:0] pwdata,
  input  logic                       drain_done,
  output int                         fail_count,
  output int                         words_pending
);
  import tcw_pkg::*;
  import tcw_tb_pkg::*;

  localparam int PRINT_CAP = 100;

  logic [CHAR_W-1:0] shadow_attr;
  int                shadow_col;
  int                shadow_row;
  cell_t             shadow_screen [CELL_COUNT];
  rsp_t              expected_words [$];
  int                errors = 0;
  int                pending_n = 0;
  bit                leftover_checked = 1'b0;

  assign fail_count    = errors;
  assign words_pending = pending_n;

  task automatic report(string msg);
    if (errors < PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    errors++;
  endtask

  function automatic void blank_screen();
    foreach (shadow_screen[i]) shadow_screen[i] = '0;
  endfunction

  // move every row up by one, last row goes blank
  function automatic void scroll_screen();
    for (int i = 0; i < CELL_COUNT - COLUMNS; i++) begin
      shadow_screen[i] = shadow_screen[i + COLUMNS];
    end
    for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
      shadow_screen[i] = '0;
    end
  endfunction

  function automatic void put_char(logic [CHAR_W-1:0] c);
    int pos;
    // line break; a pending scroll is taken first so the row stops at ROWS
    if (c == NEWLINE_CODE || shadow_col > COLUMNS - 1) begin
      if (shadow_row >= ROWS) begin
        scroll_screen();
        shadow_row = ROWS - 1;
      end
      shadow_col = 0;
      shadow_row++;
    end
    if (c == NEWLINE_CODE) return;
    // deferred scroll on the first printable past the last row
    if (shadow_row > ROWS - 1) begin
      scroll_screen();
      shadow_row = ROWS - 1;
    end
    pos = shadow_row * COLUMNS + shadow_col;
    if (pos < CELL_COUNT) begin
      shadow_screen[pos].chr  = c;
      shadow_screen[pos].attr = shadow_attr;
    end
    shadow_col++;
  endfunction

  function automatic rsp_t console_step(logic [OPC_W-1:0] op, logic [CHAR_W-1:0] c,
                                        logic [IDX_W-1:0] idx);
    rsp_t r;
    r = '0;
    case (opcode_t'(op))
      OP_PUT: put_char(c);
      OP_CLEAR: begin
        blank_screen();
        shadow_col = 0;
        shadow_row = 0;
      end
      OP_READ: begin
        if (idx < CELL_COUNT) begin
          r.cell_char = shadow_screen[idx].chr;
          r.cell_attr = shadow_screen[idx].attr;
        end
      end
      default: ;
    endcase
    r.cursor_col = shadow_col[COL_W-1:0];
    r.cursor_row = shadow_row[ROW_W-1:0];
    return r;
  endfunction

  task automatic compare_field(string name, logic [CHAR_W-1:0] got, logic [CHAR_W-1:0] want);
    if (got !== want) begin
      report($sformatf("%s got %0d want %0d", name, got, want));
    end
  endtask

  task automatic check_word();
    rsp_t want;
    if (expected_words.size() == 0) begin
      report($sformatf("word with none expected: char %0d attr %0d col %0d row %0d",
                       rsp.cell_char, rsp.cell_attr, rsp.cursor_col, rsp.cursor_row));
    end else begin
      want = expected_words.pop_front();
      compare_field("cell_char", rsp.cell_char, want.cell_char);
      compare_field("cell_attr", rsp.cell_attr, want.cell_attr);
      compare_field("cursor_col", CHAR_W'(rsp.cursor_col), CHAR_W'(want.cursor_col));
      compare_field("cursor_row", CHAR_W'(rsp.cursor_row), CHAR_W'(want.cursor_row));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      shadow_attr = ATTR_RESET;
      shadow_col  = 0;
      shadow_row  = 0;
      blank_screen();
      expected_words.delete();
    end else begin
      if (psel && penable && pwrite && pready &&
          int'(paddr) / REG_STRIDE == REG_TEXT_ATTR) begin
        shadow_attr = pwdata[CHAR_W-1:0];
      end
      // older word first: a result can never belong to a command taken this edge
      if (rsp.valid && rsp.ready) check_word();
      if (cmd.valid && cmd.ready) begin
        expected_words.push_back(console_step(cmd.opcode, cmd.char_code, cmd.cell_index));
      end
      if (drain_done && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (expected_words.size() != 0) begin
          report($sformatf("%0d expected words never arrived", expected_words.size()));
        end
      end
    end
    pending_n = expected_words.size();
  end

endmodule

@@ tb/text_console_writer_unit_tb.sv @@
// Testbench top for text_console_writer_unit: clock, reset, APB writes and
// command stimulus. Depends on tcw_pkg, tcw_tb_pkg, tcw_if and tcw_tb_checker.
module text_console_writer_unit_tb;
  import tcw_pkg::*;
  import tcw_tb_pkg::*;

  // Longest correct stretch with no handshake is the clearing pass after
  // reset or one clear/scroll; allow many times that stretch.
  localparam int HALT_LIMIT   = 20000;
  // settle time after the last expected word before touching the register
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_WORDS  = 150;
  localparam int PHASES       = 5;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              rsp_ready = 1'b0;
  logic              drain_done;
  bit                idling_on = 1'b1;
  int                rsp_stall_left = 0;
  int                quiet_cycles = 0;
  int                fail_count;
  int                words_pending;

  tcw_cmd_if cmd ();
  tcw_rsp_if rsp ();

  assign rsp.ready = rsp_ready;

  always #1 clk = ~clk;

  text_console_writer_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tcw_tb_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .rsp           (rsp),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .drain_done    (drain_done),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  // Result side back-pressure: while idling_on is set, ready drops in random bursts.
  always @(posedge clk) begin
    if (idling_on && rsp_stall_left > 0) begin
      rsp_stall_left <= rsp_stall_left - 1;
      rsp_ready      <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      rsp_stall_left <= $urandom_range(0, 3);
      rsp_ready      <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // Watchdog: any handshake on either channel or the APB port resets it.
  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HALT_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One command word. valid stays high after the handshake so that
  // back-to-back words keep it high; a gap, when drawn, lowers it first.
  task automatic send_word(opcode_t op, logic [CHAR_W-1:0] c, logic [IDX_W-1:0] idx);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    cmd.valid      <= 1'b1;
    cmd.opcode     <= op;
    cmd.char_code  <= c;
    cmd.cell_index <= idx;
    do @(posedge clk); while (!cmd.ready);
  endtask

  // Stop sending and wait until every expected word is back. Sampled on
  // the falling edge so the checker's count is settled.
  task automatic wait_drained();
    cmd.valid <= 1'b0;
    do @(negedge clk); while (words_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; pready is sampled at the access edge.
  task automatic apb_write(reg_index_t idx, logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(int'(idx) * REG_STRIDE);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [IDX_W-1:0] pick_cell();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return IDX_W'($urandom_range(0, CELL_COUNT - 1));
    // bottom rows, where fresh text and scrolled-in blanks live
    if (r < 9) return IDX_W'($urandom_range((ROWS - 5) * COLUMNS, CELL_COUNT - 1));
    return IDX_W'($urandom_range(CELL_COUNT, 2**IDX_W - 1));
  endfunction

  // Random traffic built from sequences: text runs (some long enough to
  // wrap), newline bursts that push the cursor into scroll-pending, reads,
  // and a little noise including opcode 3 and clears.
  task automatic run_random_phase(int n_words);
    int sent;
    int kind;
    int run_len;
    logic [CHAR_W-1:0] c;
    sent = 0;
    while (sent < n_words) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        run_len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 20) : $urandom_range(60, 100);
        for (int k = 0; k < run_len; k++) begin
          c = CHAR_W'($urandom_range(0, 255));
          if (c == NEWLINE_CODE) c = 8'h20;
          send_word(OP_PUT, c, IDX_W'($urandom_range(0, 2**IDX_W - 1)));
        end
        sent += run_len;
        if ($urandom_range(0, 3) != 0) begin
          send_word(OP_PUT, NEWLINE_CODE, IDX_W'($urandom_range(0, 2**IDX_W - 1)));
          sent++;
        end
      end else if (kind < 55) begin
        run_len = $urandom_range(1, 30);
        for (int k = 0; k < run_len; k++) begin
          send_word(OP_PUT, NEWLINE_CODE, pick_cell());
        end
        sent += run_len;
      end else if (kind < 85) begin
        run_len = $urandom_range(1, 5);
        for (int k = 0; k < run_len; k++) begin
          send_word(OP_READ, CHAR_W'($urandom_range(0, 255)), pick_cell());
        end
        sent += run_len;
      end else if (kind < 98) begin
        send_word(opcode_t'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                  IDX_W'($urandom_range(0, 2**IDX_W - 1)));
        sent++;
      end else begin
        send_word(OP_CLEAR, CHAR_W'($urandom_range(0, 255)), pick_cell());
        sent++;
      end
    end
  endtask

  initial begin
    logic [CHAR_W-1:0] phase_attr [PHASES];
    phase_attr = '{8'h00, 8'hFF, CHAR_W'($urandom_range(0, 255)), 8'h80,
                   CHAR_W'($urandom_range(0, 255))};

    rst            <= 1'b1;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    drain_done     <= 1'b0;
    cmd.valid      <= 1'b0;
    cmd.opcode     <= OP_NONE;
    cmd.char_code  <= '0;
    cmd.cell_index <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part, attribute still at its reset value.
    send_word(OP_READ, 8'h00, 11'd0);          // store starts cleared
    send_word(OP_PUT, 8'h41, 11'd0);
    send_word(OP_PUT, 8'h00, 11'd0);           // lowest character byte
    send_word(OP_PUT, 8'hFF, 11'h7FF);         // highest character byte
    send_word(OP_PUT, NEWLINE_CODE, 11'd0);    // newline writes no cell
    send_word(OP_READ, 8'h00, 11'd0);
    send_word(OP_READ, 8'h00, 11'd1);
    send_word(OP_READ, 8'hFF, 11'd2);
    send_word(OP_READ, 8'h00, IDX_W'(COLUMNS));
    send_word(OP_READ, 8'h00, IDX_W'(CELL_COUNT - 1)); // last cell in range
    send_word(OP_READ, 8'h00, IDX_W'(CELL_COUNT));     // first index out of range
    send_word(OP_READ, 8'h00, 11'h7FF);        // top of the index field
    send_word(OP_NONE, 8'hFF, 11'h7FF);        // unused opcode does nothing
    wait_drained();

    apb_write(REG_TEXT_ATTR, 32'h0000_00FF);
    apb_write(REG_BEYOND_LAST, 32'h0000_0000); // no register there
    send_word(OP_PUT, 8'h7E, 11'd0);
    send_word(OP_READ, 8'h00, IDX_W'(COLUMNS));
    send_word(OP_CLEAR, 8'hFF, 11'h7FF);       // clear keeps the attribute
    send_word(OP_READ, 8'h00, 11'd0);
    send_word(OP_READ, 8'h00, IDX_W'(COLUMNS));
    send_word(OP_PUT, 8'h0B, 11'd0);
    send_word(OP_READ, 8'h00, 11'd0);

    // Random phases, each under its own attribute; upper pwdata bits are
    // junk the register must drop. The last phase runs with no idling.
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      apb_write(REG_TEXT_ATTR, {APB_DW'($urandom) & ~APB_DW'(8'hFF)} | APB_DW'(phase_attr[p]));
      if (p == PHASES - 1) idling_on <= 1'b0;
      run_random_phase(PHASE_WORDS);
    end

    wait_drained();
    drain_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/tcw_pkg.sv
sv/tcw_if.sv
sv/tcw_cell_ram.sv
sv/tcw_seq.sv
sv/text_console_writer_unit.sv
tb/tcw_tb_pkg.sv
tb/tcw_tb_checker.sv
tb/text_console_writer_unit_tb.sv
